// ----- src/lsg_pkg.sv -----
// Package for the limited stencil gradient block: payload types, command and
// status structs, fixed-point constants and rounding helper.
// No dependencies.
package lsg_pkg;

  localparam int unsigned MAX_CELLS_DEF = 1024;

  localparam int unsigned GHOST_W    = 3;
  localparam int unsigned INTERIOR_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_GHOST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR = 2'd1;

  // Reciprocal divider: 2^33 / dx
  localparam int unsigned DIVIDEND_W = 34;
  localparam int unsigned DIVISOR_W  = 32;
  localparam logic [DIVIDEND_W-1:0] RECIP_NUM = 34'h2_0000_0000;

  localparam logic [31:0] SAT_MAX32 = 32'h7FFF_FFFF;
  localparam logic signed [69:0] SAT_MAX70 = 70'sd2147483647;
  localparam logic signed [69:0] SAT_MIN70 = -70'sd2147483648;

  // Stencil weights in Q2.30
  localparam logic signed [34:0] C1 = 35'sd671088640;
  localparam logic signed [34:0] C2 = 35'sd44739278;
  // floor(2^36 / 5) for the divide-by-five
  localparam logic [33:0] M_DIV5 = 34'd13743895347;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic signed [31:0] cell_position;
  } lsg_in_t;

  typedef struct packed {
    logic signed [31:0] limited_gradient;
    logic               saturated;
    logic               row_end;
  } lsg_out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_LATCH1,
    OP_LATCH2,
    OP_MUL_A,
    OP_MUL_B,
    OP_RND,
    OP_MUL_H,
    OP_GRAD,
    OP_QMUL,
    OP_QFIX,
    OP_LIMIT,
    OP_EMIT,
    OP_SHIFT
  } lsg_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV1,
    S_WAIT1,
    S_CELL,
    S_MA,
    S_MB,
    S_RND,
    S_MH,
    S_GFIN,
    S_QMUL,
    S_QFIX,
    S_LIMIT,
    S_EMIT,
    S_DIV2,
    S_WAIT2,
    S_EMITZ,
    S_UPDATE
  } lsg_state_e;

  typedef struct packed {
    lsg_op_e op;
    logic    div_sel;   // 0: spacing of window, 1: spacing to new cell
    logic    cell_b;    // 0: older cell, 1: flushed cell
    logic    side;      // 0: left gradient, 1: right gradient
    logic    first;     // one-sided difference on current side
    logic    zero;      // cell outside computed range
    logic    row_end;
  } lsg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } lsg_status_t;

  // Shift right with round to nearest, ties away from zero
  function automatic logic signed [69:0] rnd_away(input logic signed [69:0] x,
                                                   input int unsigned sh);
    logic [69:0] mag;
    logic [69:0] q;
    mag = x[69] ? 70'(-x) : 70'(x);
    q   = (mag + (70'd1 << (sh - 1))) >> sh;
    return x[69] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ----- src/lsg_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module lsg_divider #(
  parameter int unsigned DIVIDEND_W = 34,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = rem_sh >= {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- src/lsg_datapath.sv -----
// Datapath: windows, reciprocal divider, shared multiplier, stencil rounding,
// limiter and output register. Depends on lsg_pkg and lsg_divider.
module lsg_datapath
  import lsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lsg_cmd_t    cmd_i,
  output lsg_status_t status_o,
  input  lsg_in_t     in_data_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output lsg_out_t    out_data_o
);

  logic signed [31:0] val_win_q [4];
  logic signed [31:0] pos_win_q [3];
  logic [31:0]        prev_h_q, hnew_q, h2_q;
  logic signed [31:0] in_val_q, in_pos_q;
  logic               dx_nonpos_q;

  logic signed [69:0] pa_q, pb_q, m_q, t_q;
  logic signed [34:0] s_q;
  logic signed [31:0] lg_q, rg_q, l5_q, r5_q, lim_q;
  logic               flag_q;

  logic               out_valid_q;
  lsg_out_t           out_data_q;

  // cell window and side operands
  logic signed [31:0] w [5];
  logic signed [31:0] sa, sb, sc, sd;
  logic signed [32:0] d1, d3;
  logic [31:0]        h_sel;

  always_comb begin
    if (cmd_i.cell_b) begin
      w[0] = val_win_q[1];
      w[1] = val_win_q[2];
      w[2] = val_win_q[3];
      w[3] = in_val_q;
      w[4] = '0;
    end else begin
      w[0] = val_win_q[0];
      w[1] = val_win_q[1];
      w[2] = val_win_q[2];
      w[3] = val_win_q[3];
      w[4] = in_val_q;
    end
    if (cmd_i.side) begin
      sa = w[1]; sb = w[2]; sc = w[3]; sd = w[4];
      h_sel = cmd_i.cell_b ? h2_q : hnew_q;
    end else begin
      sa = w[0]; sb = w[1]; sc = w[2]; sd = w[3];
      h_sel = cmd_i.cell_b ? hnew_q : prev_h_q;
    end
    d1 = {sc[31], sc} - {sb[31], sb};
    d3 = {sd[31], sd} - {sa[31], sa};
  end

  // divider
  logic signed [32:0] dx;
  logic               div_start;
  logic               div_done;
  logic [DIVIDEND_W-1:0] quot;
  logic [31:0]        h_new;

  assign dx = cmd_i.div_sel ? ({in_pos_q[31], in_pos_q} - {pos_win_q[2][31], pos_win_q[2]})
                            : ({pos_win_q[2][31], pos_win_q[2]}
                               - {pos_win_q[1][31], pos_win_q[1]});
  assign div_start = (cmd_i.op == OP_DIV_START);
  assign h_new = (dx_nonpos_q || (quot > DIVIDEND_W'(SAT_MAX32))) ? SAT_MAX32
                                                                : quot[31:0];

  lsg_divider #(
    .DIVIDEND_W(DIVIDEND_W),
    .DIVISOR_W (DIVISOR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(RECIP_NUM),
    .divisor_i (dx[31:0]),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // gradient magnitude for divide by five
  logic signed [31:0] g_sel;
  logic [31:0]        g_mag;
  logic [33:0]        x5;
  assign g_sel = cmd_i.side ? rg_q : lg_q;
  assign g_mag = g_sel[31] ? 32'(-g_sel) : 32'(g_sel);
  assign x5    = {g_mag, 2'b00};

  // shared multiplier
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_A: begin
        mul_a = C1;
        mul_b = {{2{d1[32]}}, d1};
      end
      OP_MUL_B: begin
        mul_a = C2;
        mul_b = {{2{d3[32]}}, d3};
      end
      OP_MUL_H: begin
        mul_a = {3'b000, h_sel};
        mul_b = cmd_i.first ? {{2{d1[32]}}, d1} : s_q;
      end
      OP_QMUL: begin
        mul_a = {1'b0, x5};
        mul_b = {1'b0, M_DIV5};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // rounding and clipping of a gradient
  logic signed [69:0] s_full;
  logic signed [69:0] gr;
  logic               clip_hi, clip_lo;
  logic signed [31:0] g32;
  assign s_full  = rnd_away(pa_q - pb_q, 30);
  assign gr      = cmd_i.first ? rnd_away(m_q, 17) : rnd_away(m_q, 16);
  assign clip_hi = gr > SAT_MAX70;
  assign clip_lo = gr < SAT_MIN70;
  assign g32     = clip_hi ? $signed(SAT_MAX32) : (clip_lo ? $signed(~SAT_MAX32) : gr[31:0]);

  // divide-by-five correction
  logic [33:0]        q0, q5;
  logic [35:0]        five_q0, rem5;
  logic signed [31:0] q5_s;
  assign q0      = t_q[69:36];
  assign five_q0 = {q0, 2'b00} + {2'b00, q0};
  assign rem5    = {2'b00, x5} - five_q0;
  assign q5      = q0 + ((rem5 >= 36'd5) ? 34'd1 : 34'd0);
  assign q5_s    = g_sel[31] ? -$signed(q5[31:0]) : $signed(q5[31:0]);

  // limiter
  logic signed [32:0] lr_sum, c_full;
  logic               opp;
  logic signed [31:0] lim_v, mn, mx, cc;
  always_comb begin
    lr_sum = {lg_q[31], lg_q} + {rg_q[31], rg_q};
    c_full = (lr_sum + {32'd0, lr_sum[32]}) >>> 1;
    cc     = c_full[31:0];
    opp    = (lg_q < 0 && rg_q > 0) || (lg_q > 0 && rg_q < 0);
    mn     = l5_q;
    if (r5_q < mn) mn = r5_q;
    if (cc < mn) mn = cc;
    mx     = l5_q;
    if (r5_q > mx) mx = r5_q;
    if (cc > mx) mx = cc;
    if (opp) begin
      lim_v = '0;
    end else if (l5_q > 0 && r5_q > 0) begin
      lim_v = mn;
    end else begin
      lim_v = mx;
    end
  end

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) val_win_q[i] <= '0;
      for (int i = 0; i < 3; i++) pos_win_q[i] <= '0;
      prev_h_q <= '0;
    end else if (cmd_i.op == OP_SHIFT) begin
      val_win_q[0] <= val_win_q[1];
      val_win_q[1] <= val_win_q[2];
      val_win_q[2] <= val_win_q[3];
      val_win_q[3] <= in_val_q;
      pos_win_q[0] <= pos_win_q[1];
      pos_win_q[1] <= pos_win_q[2];
      pos_win_q[2] <= in_pos_q;
      prev_h_q     <= hnew_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        in_val_q <= in_data_i.cell_value;
        in_pos_q <= in_data_i.cell_position;
      end
      OP_DIV_START: dx_nonpos_q <= dx[32] || (dx == '0);
      OP_LATCH1:    hnew_q <= h_new;
      OP_LATCH2:    h2_q <= h_new;
      OP_MUL_A: begin
        pa_q <= prod;
        if (!cmd_i.side) flag_q <= 1'b0;
      end
      OP_MUL_B:     pb_q <= prod;
      OP_RND:       s_q <= s_full[34:0];
      OP_MUL_H:     m_q <= prod;
      OP_GRAD: begin
        if (cmd_i.side) rg_q <= g32;
        else lg_q <= g32;
        flag_q <= flag_q | clip_hi | clip_lo | (h_sel == SAT_MAX32);
      end
      OP_QMUL:      t_q <= prod;
      OP_QFIX: begin
        if (cmd_i.side) r5_q <= q5_s;
        else l5_q <= q5_s;
      end
      OP_LIMIT:     lim_q <= lim_v;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_data_q.limited_gradient <= cmd_i.zero ? '0 : lim_q;
      out_data_q.saturated        <= cmd_i.zero ? 1'b0 : flag_q;
      out_data_q.row_end          <= cmd_i.row_end;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

// ----- src/lsg_ctrl.sv -----
// Controller: configuration registers, cell counter and the sequencer that
// steps the datapath through each transaction. Depends on lsg_pkg.
module lsg_ctrl
  import lsg_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  lsg_status_t           status_i,
  output lsg_cmd_t              cmd_o
);

  localparam int unsigned CW = $clog2(MAX_CELLS + 8);
  localparam int unsigned XW = (CW > 11) ? CW : 11;

  lsg_state_e            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [GHOST_W-1:0]    ghost_q;
  logic [INTERIOR_W-1:0] inter_q;
  logic                  cell_b_q, cell_b_d;
  logic                  side_q, side_d;

  // row geometry
  logic [XW-1:0] g_x, n_x, n_c, t_x, lo_x, hi_x, k_x, j_x;
  logic          last, kge2, in_range, first_l, first_r;

  always_comb begin
    if (ghost_q < GHOST_W'(2))      g_x = XW'(2);
    else if (ghost_q > GHOST_W'(4)) g_x = XW'(4);
    else                            g_x = XW'(ghost_q);
    n_x = XW'(inter_q);
    if (n_x == '0)                        n_c = XW'(1);
    else if (n_x > XW'(MAX_CELLS - 4))    n_c = XW'(MAX_CELLS - 4);
    else                                  n_c = n_x;
    t_x      = n_c + (g_x << 1);
    lo_x     = g_x - XW'(1);
    hi_x     = n_c + g_x;
    k_x      = XW'(count_q);
    last     = (k_x + XW'(1)) >= t_x;
    kge2     = k_x >= XW'(2);
    j_x      = cell_b_q ? (k_x - XW'(1)) : (k_x - XW'(2));
    in_range = (j_x >= lo_x) && (j_x <= hi_x);
    first_l  = j_x == lo_x;
    first_r  = j_x == hi_x;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cell_b_d = cell_b_q;
    side_d   = side_q;
    cmd_o.op      = OP_NOP;
    cmd_o.div_sel = 1'b0;
    cmd_o.cell_b  = cell_b_q;
    cmd_o.side    = side_q;
    cmd_o.first   = side_q ? first_r : first_l;
    cmd_o.zero    = !in_range;
    cmd_o.row_end = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.op = OP_DIV_START;
        state_d  = S_WAIT1;
      end
      S_WAIT1: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_LATCH1;
          priority if (kge2) begin
            cell_b_d = 1'b0;
            state_d  = S_CELL;
          end else if (last) begin
            state_d = S_DIV2;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_CELL: begin
        side_d  = 1'b0;
        state_d = in_range ? S_MA : S_EMIT;
      end
      S_MA: begin
        cmd_o.op = OP_MUL_A;
        state_d  = S_MB;
      end
      S_MB: begin
        cmd_o.op = OP_MUL_B;
        state_d  = S_RND;
      end
      S_RND: begin
        cmd_o.op = OP_RND;
        state_d  = S_MH;
      end
      S_MH: begin
        cmd_o.op = OP_MUL_H;
        state_d  = S_GFIN;
      end
      S_GFIN: begin
        cmd_o.op = OP_GRAD;
        side_d   = !side_q;
        state_d  = side_q ? S_QMUL : S_MA;
      end
      S_QMUL: begin
        cmd_o.op = OP_QMUL;
        state_d  = S_QFIX;
      end
      S_QFIX: begin
        cmd_o.op = OP_QFIX;
        side_d   = !side_q;
        state_d  = side_q ? S_LIMIT : S_QMUL;
      end
      S_LIMIT: begin
        cmd_o.op = OP_LIMIT;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          priority if (cell_b_q) begin
            state_d = S_EMITZ;
          end else if (last) begin
            state_d = S_DIV2;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_DIV2: begin
        cmd_o.op      = OP_DIV_START;
        cmd_o.div_sel = 1'b1;
        state_d       = S_WAIT2;
      end
      S_WAIT2: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_LATCH2;
          cell_b_d = 1'b1;
          state_d  = S_CELL;
        end
      end
      S_EMITZ: begin
        cmd_o.zero    = 1'b1;
        cmd_o.row_end = 1'b1;
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.op = OP_SHIFT;
        count_d  = last ? '0 : (count_q + CW'(1));
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ghost_q  <= GHOST_W'(2);
      inter_q  <= INTERIOR_W'(64);
      cell_b_q <= 1'b0;
      side_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cell_b_q <= cell_b_d;
      side_q   <= side_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_GHOST: begin
            ghost_q <= cfg_data_i[GHOST_W-1:0];
            count_q <= '0;
          end
          CFG_INTERIOR: begin
            inter_q <= cfg_data_i[INTERIOR_W-1:0];
            count_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- src/limited_stencil_gradient.sv -----
// Top level of the limited stencil gradient block: controller plus datapath.
// Depends on lsg_pkg, lsg_ctrl, lsg_datapath (and lsg_divider below it).
//
// Usage:
//   A row of 2*ghost_cells + interior_cells cells streams in on the input
//   channel, one cell (value, center position, both Q16.16) per transaction.
//   Each cell result (limited gradient, saturated, row_end) leaves on the
//   output channel in cell order. Results lag two cells; the first two cells
//   of a row give none and the last cell of a row gives three, the final one
//   flagged row_end.
//   Each input gets one cell spacing reciprocal from the restoring divider,
//   the last cell of a row a second one; each computed cell then passes its
//   two gradients and their divide-by-five through the shared multiplier.
//   The block works on one transaction at a time: in_stall_o is high from
//   acceptance until the window shift after its last result is loaded.
//   The output register holds a result while the receiver stalls; the
//   sequencer waits on the output only when a result is due and the previous
//   one is still held. A new input is accepted while a result still waits.
//   Reset clears the windows, the cell counter and the output valid, and
//   loads ghost_cells = 2, interior_cells = 64. A configuration write,
//   made while idle, abandons a partial row.
module limited_stencil_gradient
  import lsg_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lsg_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lsg_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  lsg_cmd_t    cmd;
  lsg_status_t status;

  // sequencer: owns the row counter and the register file
  lsg_ctrl #(
    .MAX_CELLS(MAX_CELLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, windows and the output register
  lsg_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

// ----- tb/lsg_checker.sv -----
// Checker for limited_stencil_gradient: watches both channels and the register port,
// predicts each cell's limited gradient and compares the results in order.
// Depends on lsg_pkg.
`timescale 1ns / 1ps

module lsg_checker
  import lsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  lsg_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  lsg_out_t              out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef logic signed [127:0] wide_t;

  localparam wide_t W_MAX = 128'sd2147483647;
  localparam wide_t W_MIN = -128'sd2147483648;
  localparam wide_t K_C1  = 128'sd671088640;
  localparam wide_t K_C2  = 128'sd44739278;

  lsg_out_t         grad_expected[$];
  logic [2:0]       ghost_reg;
  logic [9:0]       interior_reg;
  wide_t            val_win[4];
  wide_t            pos_win[3];
  int unsigned      cell_idx;
  wide_t            prev_inv_dx;

  assign pending_o = grad_expected.size();

  function automatic wide_t round_div(wide_t p, wide_t d);
    wide_t q, r;
    q = p / d;
    r = p % d;
    if (r < 0) r = -r;
    if (2 * r >= d) q = (p < 0) ? q - 1 : q + 1;
    return q;
  endfunction

  function automatic wide_t inv_spacing(wide_t dx);
    wide_t q;
    if (dx <= 0) return W_MAX;
    q = (128'sd1 <<< 33) / dx;
    return (q > W_MAX) ? W_MAX : q;
  endfunction

  function automatic wide_t clip32(wide_t g, inout logic sat);
    if (g > W_MAX) begin
      sat = 1'b1;
      return W_MAX;
    end
    if (g < W_MIN) begin
      sat = 1'b1;
      return W_MIN;
    end
    return g;
  endfunction

  // a..d: values at offsets -1, 0, +1, +2 around the spacing
  function automatic wide_t stencil_grad(wide_t h, wide_t a, wide_t b, wide_t c,
                                         wide_t d, inout logic sat);
    wide_t s;
    s = round_div(K_C1 * (c - b) - K_C2 * (d - a), 128'sd1 <<< 30);
    if (h == W_MAX) sat = 1'b1;
    return clip32(round_div(h * s, 128'sd65536), sat);
  endfunction

  function automatic wide_t one_sided_grad(wide_t h, wide_t b, wide_t c, inout logic sat);
    if (h == W_MAX) sat = 1'b1;
    return clip32(round_div((c - b) * h, 128'sd1 <<< 17), sat);
  endfunction

  function automatic wide_t mc_limit(wide_t gl, wide_t gr);
    wide_t l, r, c, m;
    l = (4 * gl) / 5;
    r = (4 * gr) / 5;
    c = (gl + gr) / 2;
    m = l;
    if (gl * gr < 0) return 0;
    if (l > 0 && r > 0) begin
      if (r < m) m = r;
      if (c < m) m = c;
    end else begin
      if (r > m) m = r;
      if (c > m) m = c;
    end
    return m;
  endfunction

  // v0..v4 are the values of cells j-2 .. j+2
  function automatic lsg_out_t cell_gradient(int unsigned j, int unsigned lo, int unsigned hi,
                                             wide_t v0, wide_t v1, wide_t v2, wide_t v3,
                                             wide_t v4, wide_t hl, wide_t hr,
                                             int unsigned last);
    lsg_out_t res;
    logic     sat;
    wide_t    gl, gr, g;
    sat = 1'b0;
    g   = 0;
    if (j >= lo && j <= hi) begin
      gl = (j == lo) ? one_sided_grad(hl, v1, v2, sat) : stencil_grad(hl, v0, v1, v2, v3, sat);
      gr = (j == hi) ? one_sided_grad(hr, v2, v3, sat) : stencil_grad(hr, v1, v2, v3, v4, sat);
      g  = mc_limit(gl, gr);
    end
    res.limited_gradient = g[31:0];
    res.saturated        = sat;
    res.row_end          = (j == last);
    return res;
  endfunction

  task automatic predict_cell_gradients(input lsg_in_t d);
    int unsigned g, n, total, lo, hi, k;
    wide_t       nv, np, h_new;
    g  = (ghost_reg < 2) ? 2 : (ghost_reg > 4) ? 4 : ghost_reg;
    n  = (interior_reg < 1) ? 1 : (interior_reg > MAX_CELLS_DEF - 4) ? MAX_CELLS_DEF - 4
                                                                       : interior_reg;
    total = 2 * g + n;
    lo = g - 1;
    hi = n + g;
    k  = cell_idx;
    nv = wide_t'(d.cell_value);
    np = wide_t'(d.cell_position);
    h_new = inv_spacing(pos_win[2] - pos_win[1]);
    if (k >= 2)
      grad_expected.push_back(cell_gradient(k - 2, lo, hi, val_win[0], val_win[1], val_win[2],
                                            val_win[3], nv, prev_inv_dx, h_new, total - 1));
    if (k + 1 >= total) begin
      // last cell flushes the two still in the window
      grad_expected.push_back(cell_gradient(k - 1, lo, hi, val_win[1], val_win[2], val_win[3],
                                            nv, 0, h_new, inv_spacing(np - pos_win[2]),
                                            total - 1));
      grad_expected.push_back(cell_gradient(k, lo, hi, val_win[1], val_win[2], val_win[3],
                                            nv, 0, 0, 0, total - 1));
      cell_idx = 0;
    end else begin
      cell_idx = k + 1;
    end
    prev_inv_dx = h_new;
    val_win[0] = val_win[1]; val_win[1] = val_win[2]; val_win[2] = val_win[3]; val_win[3] = nv;
    pos_win[0] = pos_win[1]; pos_win[1] = pos_win[2]; pos_win[2] = np;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lsg_out_t want;
    if (!rst_ni) begin
      grad_expected.delete();
      ghost_reg    = 3'd2;
      interior_reg = 10'd64;
      for (int i = 0; i < 4; i++) val_win[i] = 0;
      for (int i = 0; i < 3; i++) pos_win[i] = 0;
      cell_idx     = 0;
      prev_inv_dx  = 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (grad_expected.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result grad=%0d sat=%0b end=%0b", $time,
                   out_data_i.limited_gradient, out_data_i.saturated, out_data_i.row_end);
        end else begin
          want = grad_expected.pop_front();
          checked_o++;
          if (want !== out_data_i) begin
            fail_count_o++;
            $display("%0t: mismatch expected grad=%0d sat=%0b end=%0b, got grad=%0d sat=%0b end=%0b",
                     $time, want.limited_gradient, want.saturated, want.row_end,
                     out_data_i.limited_gradient, out_data_i.saturated, out_data_i.row_end);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_cell_gradients(in_data_i);
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GHOST) begin
          ghost_reg = cfg_data_i[2:0];
          cell_idx  = 0;
        end else if (cfg_index_i == CFG_INTERIOR) begin
          interior_reg = cfg_data_i[9:0];
          cell_idx     = 0;
        end
      end
    end
  end

endmodule

// ----- tb/tb_limited_stencil_gradient.sv -----
// Testbench top for limited_stencil_gradient: clock, reset, register writes,
// cell stimulus and verdict. Depends on lsg_pkg, lsg_checker and the block itself.
`timescale 1ns / 1ps

module tb_limited_stencil_gradient;
  import lsg_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  lsg_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lsg_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GHOST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, pending, checked;
  int send_idle_pct = 0;   // percent of cycles the sender sits idle
  int recv_stall_pct = 0;  // percent of cycles the receiver stalls
  logic hold_req = 1'b0;   // asks for one long receiver hold-off
  logic hold_long = 1'b0;
  int cells_sent = 0;
  logic signed [31:0] row_pos;  // running cell center position

  always #4 clk = ~clk;

  limited_stencil_gradient dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lsg_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Receiver stall: random per cycle, plus the long hold-off when asked.
  always @(negedge clk) begin
    out_stall <= hold_long || ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off counted in its own process; the sender keeps offering
  // cells so the block backs up and stalls its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk);
    hold_long <= 1'b0;
  end

  // Offer one cell; valid stays high across back-to-back transactions.
  task automatic send_cell(input logic signed [31:0] val, input logic signed [31:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.cell_value    <= val;
    in_data.cell_position <= pos;
    do @(posedge clk); while (in_stall);
    cells_sent++;
    @(negedge clk);
  endtask

  // Register writes only once the block has drained.
  task automatic write_config(input logic [2:0] ghosts, input logic [9:0] interior);
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (200) @(negedge clk);  // a cell with no result may still be in flight
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GHOST;
    cfg_data  <= CFG_DATA_W'(ghosts);
    @(negedge clk);
    cfg_index <= CFG_INTERIOR;
    cfg_data  <= interior;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  // Mostly sane increasing spacings; sometimes zero, negative, tiny or wild.
  function automatic logic signed [31:0] pick_spacing();
    case ($urandom_range(19))
      0: return 0;
      1: return -$signed($urandom_range(1 << 16));
      2: return $urandom_range(3) + 1;
      3: return $urandom;
      default: return $urandom_range(1 << 18, 1 << 12);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) begin
      row_pos = row_pos + pick_spacing();
      send_cell(pick_value(), row_pos);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: short rows (2 ghosts, 1 interior -> 5 cells) with extreme values,
    // zero, negative and tiny spacings, and extreme positions.
    write_config(3'd2, 10'd1);
    send_cell(32'sh7FFF_FFFF, 32'sh0001_0000);
    send_cell(32'sh8000_0000, 32'sh0002_0000);
    send_cell(32'sh7FFF_FFFF, 32'sh0003_0000);
    send_cell(32'sh8000_0000, 32'sh0004_0000);
    send_cell(32'sh7FFF_FFFF, 32'sh0005_0000);
    send_cell(32'sh0000_0000, 32'sh8000_0000);
    send_cell(32'sh0001_0000, 32'sh8000_0000);  // zero spacing
    send_cell(32'sh0003_0000, 32'sh7FFF_0000);  // huge spacing
    send_cell(32'sh0002_0000, 32'sh7FFE_0000);  // negative spacing
    send_cell(32'sh0004_0000, 32'sh7FFE_0001);  // tiny spacing
    send_cell(32'sh0000_0000, 32'sh0000_0000);
    send_cell(32'sh0001_0000, 32'sh0001_0000);
    send_cell(32'sh0000_0000, 32'sh0002_0000);  // sign change: limiter gives zero
    send_cell(32'sh0001_0000, 32'sh0003_0000);
    send_cell(32'sh0002_0000, 32'sh0004_0000);
    send_cell(32'sh0004_0000, 32'sh0005_0000);  // monotone ramp
    send_cell(32'sh0008_0000, 32'sh0006_0000);
    send_cell(32'sh0010_0000, 32'sh0007_0000);
    send_cell(32'sh0020_0000, 32'sh0008_0000);
    send_cell(32'sh0040_0000, 32'sh0009_0000);

    // Random phases under several sender idle and receiver stall patterns.
    row_pos = 32'sh8000_0000;
    send_idle_pct = 0;  recv_stall_pct = 0;
    write_config(3'd4, 10'd1);
    send_random(40);
    send_idle_pct = 67; recv_stall_pct = 0;
    write_config(3'd0, 10'd0);       // both clamp up
    send_random(40);
    send_idle_pct = 0;  recv_stall_pct = 67;
    write_config(3'd7, 10'd6);       // ghosts clamp down
    send_random(50);
    send_idle_pct = 17; recv_stall_pct = 17;
    write_config(3'd3, 10'd5);
    send_random(50);
    // Pressure: receiver held off while cells keep coming.
    send_idle_pct = 0;  recv_stall_pct = 0;
    write_config(3'd2, 10'd3);
    hold_req = 1'b1;
    send_random(40);
    // Widest interior setting; the row is abandoned by the next write.
    send_idle_pct = 0;  recv_stall_pct = 30;
    write_config(3'd2, 10'd1023);
    send_random(30);
    send_idle_pct = 17; recv_stall_pct = 17;
    write_config(3'd2, 10'd64);
    send_random(68);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(negedge clk);
    $display("Sent %0d cells over eight register settings; checked %0d gradients.",
             cells_sent, checked);
    $display("Covered clamped settings, degenerate spacings, stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule
